[hdl/ritoa_pkg.sv]
// Shared types and constants for the radix integer-to-text converter.
package ritoa_pkg;

	localparam int VALUE_W    = 64;
	localparam int CHAR_W     = 8;
	localparam int RADIX_W    = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_RADIX      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIGITS_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIGITS_HIGH = 2'd2;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
	localparam logic [CHAR_W-1:0]  MINUS_CHAR  = 8'h2D;
	localparam logic [VALUE_W-1:0] MOST_NEG    = 64'h8000_0000_0000_0000;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               signed_mode;
	} in_item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_out;
		logic              last;
		logic              overflow;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic start;
		logic step;
		logic store;
		logic rd;
		logic out_minus;
		logic out_char;
		logic out_ovf;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_ovf;
		logic in_neg;
		logic neg;
		logic quot_zero;
		logic at_cap;
		logic cnt_zero;
		logic out_free;
	} sts_t;

endpackage

[hdl/ritoa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ritoa_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hdl/ritoa_ctrl.sv]
// Controller state machine: sequences division steps, digit stores and character output.
module ritoa_ctrl
	import ritoa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIV   = 3'd1;
	localparam logic [2:0] ST_MINUS = 3'd2;
	localparam logic [2:0] ST_RD    = 3'd3;
	localparam logic [2:0] ST_LD    = 3'd4;
	localparam logic [2:0] ST_OVF   = 3'd5;

	logic [2:0] state_q, state_d;
	logic [2:0] bit_cnt_q, bit_cnt_d;

	always_comb begin
		state_d   = state_q;
		bit_cnt_d = bit_cnt_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (sts.in_ovf) begin
						state_d = ST_OVF;
					end else begin
						cmd.start = 1'b1;
						bit_cnt_d = '0;
						state_d   = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				cmd.step  = 1'b1;
				bit_cnt_d = bit_cnt_q + 3'd1;
				// eighth byte step finishes one digit
				if (bit_cnt_q == 3'd7) begin
					cmd.store = 1'b1;
					if (sts.quot_zero || sts.at_cap) begin
						state_d = sts.neg ? ST_MINUS : ST_RD;
					end
				end
			end
			ST_MINUS: begin
				if (sts.out_free) begin
					cmd.out_minus = 1'b1;
					state_d       = ST_RD;
				end
			end
			ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_LD;
			end
			ST_LD: begin
				if (sts.out_free) begin
					cmd.out_char = 1'b1;
					state_d      = sts.cnt_zero ? ST_IDLE : ST_RD;
				end
			end
			ST_OVF: begin
				if (sts.out_free) begin
					cmd.out_ovf = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bit_cnt_q <= '0;
		end else begin
			state_q   <= state_d;
			bit_cnt_q <= bit_cnt_d;
		end
	end

endmodule

[hdl/ritoa_dp.sv]
// Datapath: config registers, byte-wise divider by the radix, digit store and output register.
module ritoa_dp
	import ritoa_pkg::*;
#(
	parameter int MAX_DIGITS = 64,
	parameter int MAX_RADIX  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  in_item_t              in_item,
	output out_item_t             out_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  cmd_t                  cmd,
	output sts_t                  sts
);

	localparam int DIG_W  = $clog2(MAX_RADIX);
	localparam int BASE_W = DIG_W + 1;
	localparam int ADDR_W = $clog2(MAX_DIGITS);
	localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DIGITS);

	logic [RADIX_W-1:0]    radix_q;
	logic [VALUE_W-1:0]    digits_low_q;
	logic [VALUE_W-1:0]    digits_high_q;
	logic [VALUE_W-1:0]    val_q;
	logic [DIG_W-1:0]      rem_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  neg_q;
	logic                  last_q;
	logic                  out_valid_q;
	out_item_t             out_q;

	logic [BASE_W-1:0]     base;
	logic [7:0]            qbyte;
	logic [DIG_W-1:0]      rem_next;
	logic [VALUE_W-1:0]    val_next;
	logic [DIG_W-1:0]      rd_digit;
	logic [3:0]            sym;
	logic [CHAR_W-1:0]     sym_char;
	logic [VALUE_W-1:0]    sym_word;
	logic [CNT_W-1:0]      cap;
	logic                  in_neg;

	// clamp radix into 2..MAX_RADIX
	always_comb begin
		if (radix_q < RADIX_W'(2)) begin
			base = BASE_W'(2);
		end else if (radix_q > RADIX_W'(MAX_RADIX)) begin
			base = BASE_W'(MAX_RADIX);
		end else begin
			base = BASE_W'(radix_q);
		end
	end

	// restoring division of the top byte, eight quotient bits per cycle
	always_comb begin
		logic [DIG_W-1:0]  r;
		logic [BASE_W-1:0] t;
		r     = rem_q;
		qbyte = '0;
		for (int k = 7; k >= 0; k--) begin
			t = {r, val_q[VALUE_W-8+k]};
			if (t >= base) begin
				t        = t - base;
				qbyte[k] = 1'b1;
			end
			r = t[DIG_W-1:0];
		end
		rem_next = r;
	end

	assign val_next = {val_q[VALUE_W-9:0], qbyte};
	assign in_neg   = in_item.signed_mode & in_item.value[VALUE_W-1];
	assign cap      = CNT_MAX - CNT_W'(neg_q);

	assign sts.in_ovf    = in_item.signed_mode && (in_item.value == MOST_NEG);
	assign sts.in_neg    = in_neg;
	assign sts.neg       = neg_q;
	assign sts.quot_zero = (val_next == '0);
	assign sts.at_cap    = ((cnt_q + CNT_W'(1)) == cap);
	assign sts.cnt_zero  = (cnt_q == '0);
	assign sts.out_free  = !out_valid_q || out_ready;

	ritoa_ram #(
		.WIDTH(DIG_W),
		.DEPTH(MAX_DIGITS)
	) u_digits (
		.clk  (clk),
		.we   (cmd.store),
		.waddr(cnt_q[ADDR_W-1:0]),
		.wdata(rem_next),
		.re   (cmd.rd),
		.raddr(ADDR_W'(cnt_q - CNT_W'(1))),
		.rdata(rd_digit)
	);

	assign sym      = 4'(rd_digit);
	assign sym_word = sym[3] ? digits_high_q : digits_low_q;
	assign sym_char = sym_word[{sym[2:0], 3'b000} +: CHAR_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q       <= RADIX_RESET;
			digits_low_q  <= '0;
			digits_high_q <= '0;
			cnt_q         <= '0;
			neg_q         <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_RADIX:       radix_q       <= cfg_data[RADIX_W-1:0];
					REG_DIGITS_LOW:  digits_low_q  <= cfg_data;
					REG_DIGITS_HIGH: digits_high_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (cmd.start) begin
				cnt_q <= '0;
				neg_q <= in_neg;
			end else if (cmd.store) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (cmd.rd) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (cmd.out_minus || cmd.out_char || cmd.out_ovf) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			val_q <= in_neg ? (~in_item.value + VALUE_W'(1)) : in_item.value;
			rem_q <= '0;
		end else if (cmd.step) begin
			val_q <= val_next;
			// each digit restarts from a zero remainder
			rem_q <= cmd.store ? '0 : rem_next;
		end
		if (cmd.rd) begin
			last_q <= (cnt_q == CNT_W'(1));
		end
		if (cmd.out_minus) begin
			out_q <= '{char_out: MINUS_CHAR, last: 1'b0, overflow: 1'b0};
		end else if (cmd.out_char) begin
			out_q <= '{char_out: sym_char, last: last_q, overflow: 1'b0};
		end else if (cmd.out_ovf) begin
			out_q <= '{char_out: '0, last: 1'b1, overflow: 1'b1};
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

[hdl/radix_integer_to_ascii_top.sv]
// Radix integer-to-text converter: one 64-bit value in, one character item per digit out.
// Each digit takes one division step per dividend byte (one dividend byte per cycle); the
// characters then come out most significant digit first, after a leading '-' for a negative
// signed value, each read from the digit store and then loaded into the output register.
// The most negative signed value gives one overflow item; a new value is taken only when idle.
// Reset clears control state and loads radix 10 and all-zero digit tables.
module radix_integer_to_ascii_top
	import ritoa_pkg::*;
#(
	parameter int MAX_DIGITS = 64,
	parameter int MAX_RADIX  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_item,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	ritoa_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	ritoa_dp #(
		.MAX_DIGITS(MAX_DIGITS),
		.MAX_RADIX (MAX_RADIX)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_item),
		.out_item (out_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule

[dv/radix_integer_to_ascii_top_test.sv]
// Testbench for radix_integer_to_ascii_top: directed and random values, radices and tables, predicted and checked per character.
module radix_integer_to_ascii_top_test;
	import ritoa_pkg::*;

	localparam int TEXT_MAX  = 64;
	localparam int RADIX_MAX = 16;
	localparam int SETTLE_CYCLES = 16;
	localparam int PRINT_MAX = 40;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [CFG_DATA_W-1:0] HEX_LOW  = 64'h3736_3534_3332_3130;
	localparam logic [CFG_DATA_W-1:0] HEX_HIGH = 64'h4645_4443_4241_3938;
	localparam logic [VALUE_W-1:0] ALL_ONES = '1;
	localparam logic [VALUE_W-1:0] MOST_POS = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef enum {PACE_FULL, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	in_item_t              in_item;
	logic                  out_valid;
	logic                  out_ready;
	out_item_t             out_item;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	// shadow of the configuration registers
	logic [RADIX_W-1:0]    radix_cfg;
	logic [CFG_DATA_W-1:0] glyphs_low;
	logic [CFG_DATA_W-1:0] glyphs_high;

	out_item_t expected_chars[$];
	int err_count = 0;
	int char_count = 0;
	int send_pct = 0;
	int recv_pct = 0;
	int hold_req = 0;
	int hold_left = 0;

	radix_integer_to_ascii_top #(
		.MAX_DIGITS(TEXT_MAX),
		.MAX_RADIX (RADIX_MAX)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic logic [CHAR_W-1:0] digit_glyph(logic [3:0] d);
		logic [CFG_DATA_W-1:0] word;
		word = d[3] ? glyphs_high : glyphs_low;
		return word[d[2:0]*8 +: 8];
	endfunction

	// Append the characters that one value turns into under the current settings.
	function automatic void predict_text(logic [VALUE_W-1:0] value, logic smode);
		logic [VALUE_W-1:0] mag;
		logic [VALUE_W-1:0] base;
		logic [3:0]         digits[TEXT_MAX];
		logic               neg;
		int                 count;
		int                 cap;
		out_item_t          res;
		base = radix_cfg;
		if (base < 2)
			base = 2;
		if (base > RADIX_MAX)
			base = RADIX_MAX;
		if (smode && value == MOST_NEG) begin
			res.char_out = '0;
			res.last = 1'b1;
			res.overflow = 1'b1;
			expected_chars.push_back(res);
			return;
		end
		neg = smode & value[VALUE_W-1];
		mag = neg ? (~value + 1'b1) : value;
		count = 0;
		cap = TEXT_MAX - int'(neg);
		do begin
			digits[count] = 4'(mag % base);
			mag = mag / base;
			count++;
		end while (mag != 0 && count < cap);
		if (neg) begin
			res.char_out = MINUS_CHAR;
			res.last = 1'b0;
			res.overflow = 1'b0;
			expected_chars.push_back(res);
		end
		for (int i = count - 1; i >= 0; i--) begin
			res.char_out = digit_glyph(digits[i]);
			res.last = (i == 0);
			res.overflow = 1'b0;
			expected_chars.push_back(res);
		end
	endfunction

	task automatic report_mismatch(string msg);
		if (err_count < PRINT_MAX)
			$display("MISMATCH at %0t: %s", $realtime, msg);
		err_count++;
	endtask

	// Check every character item against the oldest prediction.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_chars.size() == 0) begin
				report_mismatch($sformatf("unexpected char %02h last %b ovf %b",
					out_item.char_out, out_item.last, out_item.overflow));
			end else begin
				want = expected_chars.pop_front();
				if (out_item.char_out !== want.char_out)
					report_mismatch($sformatf("char %0d char_out got %02h want %02h",
						char_count, out_item.char_out, want.char_out));
				if (out_item.last !== want.last)
					report_mismatch($sformatf("char %0d last got %b want %b",
						char_count, out_item.last, want.last));
				if (out_item.overflow !== want.overflow)
					report_mismatch($sformatf("char %0d overflow got %b want %b",
						char_count, out_item.overflow, want.overflow));
			end
			char_count++;
		end
	end

	// Receiver: random stalls, plus a long hold-off when one is requested.
	always @(negedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready = 1'b0;
		end else begin
			out_ready = ($urandom_range(99) >= recv_pct);
		end
	end

	task automatic set_pace(pace_t pace);
		send_pct = (pace == PACE_SEND_IDLE) ? 73 : (pace == PACE_BOTH) ? 9 : 0;
		recv_pct = (pace == PACE_RECV_STALL) ? 73 : (pace == PACE_BOTH) ? 9 : 0;
	endtask

	// Called at a falling edge; returns at a falling edge.
	task automatic send_value(logic [VALUE_W-1:0] value, logic smode);
		in_item.value = value;
		in_item.signed_mode = smode;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		predict_text(value, smode);
		@(negedge clk);
		while ($urandom_range(99) < send_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = data;
		@(posedge clk);
		case (idx)
			REG_RADIX:       radix_cfg = data[RADIX_W-1:0];
			REG_DIGITS_LOW:  glyphs_low = data;
			REG_DIGITS_HIGH: glyphs_high = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Drop valid and wait until every predicted character has come out.
	task automatic settle();
		in_valid = 1'b0;
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_radix(int r);
		write_reg(REG_RADIX, {$urandom, $urandom} & ~64'h1F | 64'(r));
	endtask

	function automatic logic [VALUE_W-1:0] rand_operand();
		logic [VALUE_W-1:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0, 1: v = v >> $urandom_range(1, 63);
			2, 3: v = ~(v >> $urandom_range(1, 63)) + 1'b1;
			4: v = MOST_NEG;
			5: begin
				case ($urandom_range(0, 3))
					0: v = '0;
					1: v = 64'd1;
					2: v = ALL_ONES;
					default: v = MOST_POS;
				endcase
			end
			default: ;
		endcase
		return v;
	endfunction

	// Reset settings: radix 10 with all-zero tables.
	task automatic test_reset_tables();
		send_value(64'd0, 1'b0);
		send_value(64'd12345, 1'b0);
		send_value(-64'sd5, 1'b1);
		settle();
	endtask

	task automatic test_extremes();
		write_reg(REG_DIGITS_LOW, HEX_LOW);
		write_reg(REG_DIGITS_HIGH, HEX_HIGH);
		send_value(64'd0, 1'b0);
		send_value(ALL_ONES, 1'b0);
		send_value(ALL_ONES, 1'b1);
		send_value(MOST_NEG, 1'b1);
		send_value(MOST_NEG, 1'b0);
		send_value(MOST_POS, 1'b1);
		send_value(MOST_NEG + 1, 1'b1);
		settle();
		set_radix(16);
		send_value(ALL_ONES, 1'b0);
		send_value(64'hFEDC_BA98_7654_3210, 1'b0);
		send_value(64'h0123_4567_89AB_CDEF, 1'b1);
		settle();
		set_radix(2);
		send_value(ALL_ONES, 1'b0);
		send_value(MOST_NEG + 1, 1'b1);
		send_value(64'd1, 1'b0);
		settle();
	endtask

	// Out-of-range radix values clamp to the nearest legal base.
	task automatic test_radix_clamp();
		set_radix(0);
		send_value(64'd5, 1'b0);
		settle();
		set_radix(1);
		send_value(64'd5, 1'b1);
		settle();
		set_radix(31);
		send_value(64'hFF, 1'b0);
		settle();
		set_radix(17);
		send_value(-64'sd255, 1'b1);
		settle();
		write_reg(REG_UNUSED, {$urandom, $urandom});
		send_value(64'd77, 1'b0);
		settle();
	endtask

	task automatic test_random_phases();
		pace_t pace;
		for (int phase = 0; phase < 5; phase++) begin
			pace = pace_t'(phase % 4);
			case ($urandom_range(0, 5))
				0: set_radix(2);
				1: set_radix(RADIX_MAX);
				2: set_radix($urandom_range(0, 1));
				3: set_radix($urandom_range(17, 31));
				default: set_radix($urandom_range(2, RADIX_MAX));
			endcase
			case ($urandom_range(0, 2))
				0: begin
					write_reg(REG_DIGITS_LOW, '1);
					write_reg(REG_DIGITS_HIGH, '1);
				end
				1: begin
					write_reg(REG_DIGITS_LOW, HEX_LOW);
					write_reg(REG_DIGITS_HIGH, HEX_HIGH);
				end
				default: begin
					write_reg(REG_DIGITS_LOW, {$urandom, $urandom});
					write_reg(REG_DIGITS_HIGH, {$urandom, $urandom});
				end
			endcase
			set_pace(pace);
			for (int k = 0; k < 45; k++)
				send_value(rand_operand(), $urandom_range(0, 1));
			settle();
		end
		set_pace(PACE_FULL);
	endtask

	// Hold the output off while items keep coming, so the input stalls.
	task automatic test_backpressure();
		set_radix(2);
		set_pace(PACE_FULL);
		hold_req = 1500;
		for (int k = 0; k < 10; k++)
			send_value(rand_operand(), $urandom_range(0, 1));
		settle();
	endtask

	task automatic test_sender_pause();
		set_radix($urandom_range(2, RADIX_MAX));
		set_pace(PACE_RECV_STALL);
		for (int k = 0; k < 4; k++)
			send_value(rand_operand(), $urandom_range(0, 1));
		in_valid = 1'b0;
		while (expected_chars.size() != 0)
			@(negedge clk);
		for (int k = 0; k < 4; k++)
			send_value(rand_operand(), $urandom_range(0, 1));
		settle();
		set_pace(PACE_FULL);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		out_ready = 1'b0;
		radix_cfg = RADIX_RESET;
		glyphs_low = '0;
		glyphs_high = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_tables();
		test_extremes();
		test_radix_clamp();
		test_random_phases();
		test_backpressure();
		test_sender_pause();
		if (err_count == 0)
			$display("radix_integer_to_ascii_top test passed");
		else
			$display("radix_integer_to_ascii_top test failed");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("radix_integer_to_ascii_top test failed");
		$finish;
	end

endmodule
